>>> src/ntwa_pkg.sv
`default_nettype none
package ntwa_pkg;

	localparam int unsigned TableEntriesDefault = 128;
	localparam logic [15:0] AgeLimitReset = 16'd300;
	localparam logic [7:0]  ValidMaskReset = 8'd222;
	localparam logic [7:0]  RemoveMaskReset = 8'd33;

	localparam logic [1:0] CmdUpdate   = 2'd0;
	localparam logic [1:0] CmdDelete   = 2'd1;
	localparam logic [1:0] CmdSweep    = 2'd2;
	localparam logic [1:0] CmdReserved = 2'd3;

	localparam logic [1:0] RegAgeLimit   = 2'd0;
	localparam logic [1:0] RegValidMask  = 2'd1;
	localparam logic [1:0] RegRemoveMask = 2'd2;

	// stored entry word: mac, ipv4, interface, seen time, state
	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] ipv4;
		logic [7:0]  iface;
		logic [31:0] seen_time;
		logic [7:0]  state;
	} entry_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [47:0] mac_address;
		logic [31:0] ipv4_address;
		logic [7:0]  interface_id;
		logic [7:0]  neighbor_state;
		logic [31:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic        found;
		logic [6:0]  slot_index;
		logic        evicted;
		logic [47:0] evicted_mac;
		logic        table_changed;
		logic [7:0]  aged_out_count;
		logic [7:0]  valid_count;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_WRITE,
		ST_OUT
	} ctl_state_t;

endpackage
`default_nettype wire

>>> src/ntwa_ram.sv
`default_nettype none
module ntwa_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output      logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/neighbor_table_with_aging_core.sv
// Neighbour table with aging, keyed by 48-bit MAC.
// Channels: in_valid/in_ready carry one in_word_t command word (update,
// delete, age sweep); out_valid/out_ready carry one out_word_t result word
// per command. Registers are written through the APB-style port; pready is
// always high and writes complete in the access cycle.
// Each command makes one pass over the entry memory, reading one slot per
// cycle (single read port), then goes through a decide state, a write
// state and an output state; out_valid rises as the result register is
// loaded. A new word is taken only in the idle state that follows, so the
// block takes no new word before it is through with the last one.
// The sweep clears the valid bit of each aged slot during its pass.
// Valid bits sit in flip-flops that reset clears at once; entry memory
// content is left undefined until written. Configuration resets to age
// limit 300, valid mask 0xDE, remove mask 0x21.
// While the receiver stalls the result is held; the next command runs its
// pass meanwhile and waits in its output state until the result is taken.
`default_nettype none
module neighbor_table_with_aging_core #(
	parameter int unsigned TABLE_ENTRIES = ntwa_pkg::TableEntriesDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire ntwa_pkg::in_word_t in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      ntwa_pkg::out_word_t out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready
);

	localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

	// configuration registers
	logic [15:0] age_limit_q;
	logic [7:0]  vmask_q, rmask_q;
	logic        cfg_we;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= ntwa_pkg::AgeLimitReset;
			vmask_q     <= ntwa_pkg::ValidMaskReset;
			rmask_q     <= ntwa_pkg::RemoveMaskReset;
		end else if (cfg_we) begin
			unique case (reg_idx)
				ntwa_pkg::RegAgeLimit:   age_limit_q <= pwdata[15:0];
				ntwa_pkg::RegValidMask:  vmask_q <= pwdata[7:0];
				ntwa_pkg::RegRemoveMask: rmask_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ntwa_pkg::RegAgeLimit:   prdata = {16'd0, age_limit_q};
			ntwa_pkg::RegValidMask:  prdata = {24'd0, vmask_q};
			ntwa_pkg::RegRemoveMask: prdata = {24'd0, rmask_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// control and scan state
	ntwa_pkg::ctl_state_t state_q, state_d;
	ntwa_pkg::in_word_t   cmd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CntW-1:0] total_q;
	logic [IdxW-1:0] rd_idx_q;      // address issued this cycle
	logic [IdxW-1:0] chk_idx_q;     // address whose data is on rdata
	logic            chk_v_q;       // rdata is valid for chk_idx_q
	logic            hit_q, free_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [31:0]     old_ts_q;
	logic [47:0]     old_mac_q;
	logic            old_v_q;
	logic [7:0]      aged_q;
	ntwa_pkg::out_word_t res_q, res_d;
	logic            out_v_q;
	logic            res_ld;

	ntwa_pkg::entry_t rd_data, wr_data;
	logic             mem_we;
	logic [IdxW-1:0]  mem_waddr;

	ntwa_ram #(
		.Width($bits(ntwa_pkg::entry_t)),
		.Depth(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(wr_data),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	logic is_upd, is_del, upd_hit_mask, rem_hit_mask;
	logic [31:0] age;
	logic        chk_live, aged_now;
	logic [IdxW-1:0] tgt_idx;

	assign is_upd = cmd_q.cmd == ntwa_pkg::CmdUpdate;
	assign is_del = cmd_q.cmd == ntwa_pkg::CmdDelete;
	assign upd_hit_mask = is_upd && ((cmd_q.neighbor_state & vmask_q) != 8'd0);
	assign rem_hit_mask = (cmd_q.neighbor_state & rmask_q) != 8'd0;
	assign chk_live = chk_v_q && valid_q[chk_idx_q];
	assign age = (cmd_q.now_seconds >= rd_data.seen_time) ?
		cmd_q.now_seconds - rd_data.seen_time : 32'd0;
	assign aged_now = (state_q == ntwa_pkg::ST_SCAN) && chk_live &&
		(cmd_q.cmd == ntwa_pkg::CmdSweep) && (age > {16'd0, age_limit_q});
	assign tgt_idx = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
	// result register free: load it and leave the output cycle
	assign res_ld = (state_q == ntwa_pkg::ST_OUT) && (!out_v_q || out_ready);

	// entry write: new/refreshed entry on an update whose state hits the valid mask, otherwise nothing
	always_comb begin
		wr_data.mac       = cmd_q.mac_address;
		wr_data.ipv4      = cmd_q.ipv4_address;
		wr_data.iface     = cmd_q.interface_id;
		wr_data.seen_time = cmd_q.now_seconds;
		wr_data.state     = cmd_q.neighbor_state;
		mem_waddr         = tgt_idx;
		mem_we = (state_q == ntwa_pkg::ST_WRITE) && upd_hit_mask;
	end

	// next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ntwa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ntwa_pkg::ST_SCAN;
				end
			end
			ntwa_pkg::ST_SCAN: begin
				if (chk_v_q && chk_idx_q == LastIdx) begin
					state_d = ntwa_pkg::ST_DECIDE;
				end
			end
			ntwa_pkg::ST_DECIDE: state_d = ntwa_pkg::ST_WRITE;
			ntwa_pkg::ST_WRITE:  state_d = ntwa_pkg::ST_OUT;
			ntwa_pkg::ST_OUT: begin
				if (res_ld) begin
					state_d = ntwa_pkg::ST_IDLE;
				end
			end
			default:             state_d = ntwa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture command word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_data;
		end
	end

	// scan pipeline: address then compare in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			chk_idx_q  <= '0;
			chk_v_q    <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			old_v_q    <= 1'b0;
			aged_q     <= '0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			old_idx_q  <= '0;
			old_ts_q   <= '0;
			old_mac_q  <= '0;
		end else if (state_q == ntwa_pkg::ST_IDLE) begin
			rd_idx_q <= '0;
			chk_v_q  <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			old_v_q  <= 1'b0;
			aged_q   <= '0;
		end else if (state_q == ntwa_pkg::ST_SCAN) begin
			chk_idx_q <= rd_idx_q;
			chk_v_q   <= !(chk_v_q && chk_idx_q == LastIdx);
			if (rd_idx_q != LastIdx) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (chk_v_q) begin
				// first hit, first free slot, oldest (lowest index on ties)
				if (chk_live && rd_data.mac == cmd_q.mac_address && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= chk_idx_q;
				end
				if (!valid_q[chk_idx_q] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= chk_idx_q;
				end
				if (!old_v_q || rd_data.seen_time < old_ts_q) begin
					old_v_q   <= 1'b1;
					old_idx_q <= chk_idx_q;
					old_ts_q  <= rd_data.seen_time;
					old_mac_q <= rd_data.mac;
				end
				if (aged_now) begin
					aged_q <= aged_q + 8'd1;
				end
			end
		end
	end

	// valid bits and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (aged_now) begin
			valid_q[chk_idx_q] <= 1'b0;
			total_q <= total_q - 1'b1;
		end else if (state_q == ntwa_pkg::ST_WRITE) begin
			if (upd_hit_mask) begin
				valid_q[tgt_idx] <= 1'b1;
				if (!hit_q && free_q) begin
					total_q <= total_q + 1'b1;
				end
			end else if (is_del || is_upd) begin
				if (hit_q && rem_hit_mask) begin
					valid_q[hit_idx_q] <= 1'b0;
					total_q <= total_q - 1'b1;
				end
			end
		end
	end

	// result word
	always_comb begin
		res_d             = '0;
		res_d.valid_count = 8'(total_q);
		if (cmd_q.cmd == ntwa_pkg::CmdSweep) begin
			res_d.aged_out_count = aged_q;
			res_d.table_changed  = aged_q != 8'd0;
		end else if (upd_hit_mask) begin
			res_d.found         = hit_q;
			res_d.slot_index    = 7'(tgt_idx);
			res_d.evicted       = !hit_q && !free_q;
			res_d.evicted_mac   = (!hit_q && !free_q) ? old_mac_q : 48'd0;
			res_d.table_changed = 1'b1;
		end else if (is_del || is_upd) begin
			res_d.found = hit_q;
			if (hit_q && rem_hit_mask) begin
				res_d.slot_index    = 7'(hit_idx_q);
				res_d.table_changed = 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= res_ld || (out_v_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = res_q;

	// checks
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ntwa_pkg::ST_IDLE) |-> !in_ready)
		else $error("word taken while busy");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed under stall");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CntW'(TABLE_ENTRIES))
		else $error("valid count overflow");

endmodule
`default_nettype wire

>>> tb/tb_neighbor_table_with_aging_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_neighbor_table_with_aging_core;

	localparam int NSLOT = 128;

	// scoreboard: holds the table image and the queue of predicted result words
	class nbr_scoreboard;
		logic [15:0] age_limit;
		logic [7:0]  valid_mask;
		logic [7:0]  remove_mask;
		bit          slot_used [NSLOT];
		logic [47:0] slot_mac [NSLOT];
		logic [31:0] slot_seen [NSLOT];
		ntwa_pkg::out_word_t pending [$];
		int          mismatches;

		function new();
			age_limit = ntwa_pkg::AgeLimitReset;
			valid_mask = ntwa_pkg::ValidMaskReset;
			remove_mask = ntwa_pkg::RemoveMaskReset;
			mismatches = 0;
			foreach (slot_used[i]) slot_used[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				ntwa_pkg::RegAgeLimit: age_limit = val[15:0];
				ntwa_pkg::RegValidMask: valid_mask = val[7:0];
				ntwa_pkg::RegRemoveMask: remove_mask = val[7:0];
				default: ;
			endcase
		endfunction

		function int find_mac(logic [47:0] mac);
			for (int i = 0; i < NSLOT; i++)
				if (slot_used[i] && slot_mac[i] == mac) return i;
			return -1;
		endfunction

		// work out the result word of one accepted command word
		function void note_command(ntwa_pkg::in_word_t w);
			ntwa_pkg::out_word_t r;
			int s;
			int cnt;
			logic [31:0] age;
			r = '0;
			if (w.cmd == ntwa_pkg::CmdSweep) begin
				for (int i = 0; i < NSLOT; i++) begin
					if (!slot_used[i]) continue;
					age = (w.now_seconds >= slot_seen[i]) ?
						w.now_seconds - slot_seen[i] : 32'd0;
					if (age > {16'd0, age_limit}) begin
						slot_used[i] = 0;
						r.aged_out_count++;
					end
				end
				r.table_changed = r.aged_out_count != 0;
			end else if (w.cmd == ntwa_pkg::CmdUpdate &&
					(w.neighbor_state & valid_mask) != 0) begin
				s = find_mac(w.mac_address);
				if (s >= 0) r.found = 1;
				else begin
					for (int i = 0; i < NSLOT; i++)
						if (!slot_used[i]) begin s = i; break; end
					if (s < 0) begin
						s = 0;
						for (int i = 1; i < NSLOT; i++)
							if (slot_seen[i] < slot_seen[s]) s = i;
						r.evicted = 1;
						r.evicted_mac = slot_mac[s];
					end
					slot_mac[s] = w.mac_address;
				end
				slot_seen[s] = w.now_seconds;
				slot_used[s] = 1;
				r.slot_index = s[6:0];
				r.table_changed = 1;
			end else if (w.cmd == ntwa_pkg::CmdUpdate || w.cmd == ntwa_pkg::CmdDelete) begin
				s = find_mac(w.mac_address);
				if (s >= 0) begin
					r.found = 1;
					if ((w.neighbor_state & remove_mask) != 0) begin
						slot_used[s] = 0;
						r.slot_index = s[6:0];
						r.table_changed = 1;
					end
				end
			end
			cnt = 0;
			foreach (slot_used[i]) cnt += slot_used[i];
			r.valid_count = cnt[7:0];
			pending.push_back(r);
		endfunction

		function void check_result(ntwa_pkg::out_word_t got);
			ntwa_pkg::out_word_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp f%0d s%0d e%0d m%h c%0d a%0d v%0d,",
						" got f%0d s%0d e%0d m%h c%0d a%0d v%0d"},
						exp.found, exp.slot_index, exp.evicted, exp.evicted_mac,
						exp.table_changed, exp.aged_out_count, exp.valid_count,
						got.found, got.slot_index, got.evicted, got.evicted_mac,
						got.table_changed, got.aged_out_count, got.valid_count);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	ntwa_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	ntwa_pkg::out_word_t out_data;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	bit calm = 0;
	nbr_scoreboard sb;
	logic [47:0] mac_pool [16];
	logic [31:0] clock_s;

	always #5 clk = ~clk;

	neighbor_table_with_aging_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// receiver with random stall bursts
	initial begin
		int hold;
		sb = new();
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				hold = $urandom_range(1, 10);
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// valid drops only for an idle gap, so back-to-back words see one update
	task automatic send_word(ntwa_pkg::in_word_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_data <= w;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_command(w);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	function automatic ntwa_pkg::in_word_t make_word(logic [1:0] c, logic [47:0] m,
			logic [7:0] st, logic [31:0] t);
		ntwa_pkg::in_word_t w;
		w.cmd = c;
		w.mac_address = m;
		w.ipv4_address = $urandom;
		w.interface_id = 8'($urandom);
		w.neighbor_state = st;
		w.now_seconds = t;
		return w;
	endfunction

	// random phase: mostly updates on MACs drawn near a small pool, some deletes, sweeps and reserved codes
	task automatic random_phase(int n, int pool);
		int k;
		logic [1:0] c;
		logic [47:0] m;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			c = (k < 60) ? ntwa_pkg::CmdUpdate : (k < 80) ? ntwa_pkg::CmdDelete :
				(k < 95) ? ntwa_pkg::CmdSweep : ntwa_pkg::CmdReserved;
			if ($urandom_range(0, 9) == 0) clock_s = clock_s - $urandom_range(0, 50);
			else clock_s = clock_s + $urandom_range(0, 40);
			m = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
				mac_pool[$urandom_range(0, pool - 1)] ^ ($urandom_range(0, 200) < 1 ?
				48'd0 : {41'd0, 7'($urandom_range(0, 127))});
			send_word(make_word(c, m, 8'($urandom), clock_s));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		clock_s = 1000;

		// directed: field extremes, every command, unused code, backwards time
		send_word(make_word(ntwa_pkg::CmdUpdate, 48'd0, 8'hFF, 32'd0));
		send_word(make_word(ntwa_pkg::CmdUpdate, '1, 8'h02, '1));
		send_word(make_word(ntwa_pkg::CmdUpdate, '1, 8'h01, 32'd5));
		send_word(make_word(ntwa_pkg::CmdDelete, 48'h123, 8'hFF, 32'd5));
		send_word(make_word(ntwa_pkg::CmdReserved, 48'd0, 8'hFF, 32'd5));
		send_word(make_word(ntwa_pkg::CmdSweep, 48'd0, 8'h00, 32'd100));
		send_word(make_word(ntwa_pkg::CmdSweep, 48'd0, 8'h00, 32'd301));
		send_word(make_word(ntwa_pkg::CmdDelete, '1, 8'h21, 32'd0));
		send_word(make_word(ntwa_pkg::CmdDelete, '1, 8'h20, 32'd0));
		send_word(make_word(ntwa_pkg::CmdUpdate, 48'hAAAA_5555_AAAA, 8'h80,
			32'h5555_AAAA));
		send_word(make_word(ntwa_pkg::CmdSweep, 48'd0, 8'h00, 32'd10));
		drain();

		// fill the table past full to force evictions, limit zero
		write_reg(ntwa_pkg::RegAgeLimit, 32'd0);
		write_reg(ntwa_pkg::RegValidMask, 32'hFF);
		write_reg(ntwa_pkg::RegRemoveMask, 32'h00);
		for (int i = 0; i < 140; i++)
			send_word(make_word(ntwa_pkg::CmdUpdate, {16'hBEEF, 32'(i)},
				8'($urandom_range(1, 255)), 32'($urandom_range(0, 60))));
		send_word(make_word(ntwa_pkg::CmdDelete, {16'hBEEF, 32'd139}, 8'hFF, 32'd0));
		send_word(make_word(ntwa_pkg::CmdSweep, 48'd0, 8'h00, 32'd30));
		send_word(make_word(ntwa_pkg::CmdSweep, 48'd0, 8'h00, '1));
		drain();

		write_reg(ntwa_pkg::RegAgeLimit, 32'hFFFF);
		write_reg(ntwa_pkg::RegValidMask, 32'h00);
		write_reg(ntwa_pkg::RegRemoveMask, 32'hFF);
		random_phase(150, 16);
		drain();

		write_reg(ntwa_pkg::RegAgeLimit, 32'd1);
		write_reg(ntwa_pkg::RegValidMask, 32'h55);
		write_reg(ntwa_pkg::RegRemoveMask, 32'hAA);
		random_phase(300, 16);
		drain();

		write_reg(ntwa_pkg::RegAgeLimit, 32'd300);
		write_reg(ntwa_pkg::RegValidMask, 32'd222);
		write_reg(ntwa_pkg::RegRemoveMask, 32'd33);
		random_phase(450, 16);
		calm = 1;
		random_phase(200, 16);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> neighbor_table_with_aging_core.f
src/ntwa_pkg.sv
src/ntwa_ram.sv
src/neighbor_table_with_aging_core.sv
tb/tb_neighbor_table_with_aging_core.sv
